[hw/rtl/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU lookup unit.
// ----------------------------------------------------------------------------
package sacl_pkg;

    // Geometry of the cache directory.
    localparam int WAYS        = 8;
    localparam int SETS        = 256;
    localparam int WAY_W       = $clog2(WAYS);
    localparam int SET_W       = $clog2(SETS);
    localparam int ADDR_W      = 32;
    localparam int TAG_W       = 32;
    localparam int RANK_W      = 3;
    localparam int FILL_W      = 4;
    localparam int SHAMT_W     = 6;
    localparam int QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int OFS_W      = 5;
    localparam int IDXB_W     = 4;
    localparam int USE_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [OFS_W-1:0]  OFFSET_BITS_RST = 5'd4;
    localparam logic [IDXB_W-1:0] INDEX_BITS_RST  = 4'd8;
    localparam logic [USE_W-1:0]  WAYS_IN_USE_RST = 4'd8;

    // One classified lookup waiting for the back end.
    typedef struct packed {
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic [USE_W-1:0] use_ways;
    } lookup_t;

    // One directory row: all tags, ranks and the fill count of a set.
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0]  tags;
        logic [WAYS-1:0][RANK_W-1:0] ranks;
        logic [FILL_W-1:0]           fill;
    } row_t;

    // Back end sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_UPDATE
    } back_state_t;

endpackage

[hw/rtl/set_assoc_cache_lru_lookup_unit.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_unit
// Set-associative cache directory lookup with true LRU replacement.
// ----------------------------------------------------------------------------
// Each accepted address item is split into set and tag by the front end and
// queued (two entries). The back end works on one item at a time: BK_IDLE
// pops it and reads the whole set row (tags, ranks, fill count) from the
// single port directory memory, BK_UPDATE compares, updates recency and writes
// the row back while loading the result register. That read-modify-write of
// one memory port keeps a new item out until the row is written back. A
// result that is not taken holds the back end, and the queue then fills and
// drops in_ready. Fill counts come out of reset as zero through per-set valid
// bits, so no clearing pass is run.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sacl_pkg::ADDR_W-1:0]     address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic [sacl_pkg::WAY_W-1:0]      way,
    output logic                            evicted
);
    import sacl_pkg::*;

    lookup_t lookup;
    lookup_t q_head;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;

    assign in_ready = !q_full;

    // Front end: configuration and address split.
    sacl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .address   (address),
        .lookup    (lookup)
    );

    // Decoupling queue.
    sacl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_data (lookup),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: directory access and replacement.
    sacl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .way       (way),
        .evicted   (evicted)
    );

endmodule

[hw/rtl/sacl_front.sv]
// ----------------------------------------------------------------------------
// sacl_front
// Configuration registers and address classification into set and tag.
// ----------------------------------------------------------------------------
module sacl_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [sacl_pkg::ADDR_W-1:0]    address,
    output sacl_pkg::lookup_t              lookup
);
    import sacl_pkg::*;

    logic [OFS_W-1:0]   offset_bits_reg;
    logic [IDXB_W-1:0]  index_bits_reg;
    logic [USE_W-1:0]   ways_in_use_reg;
    logic [IDXB_W-1:0]  ib;
    logic [USE_W-1:0]   use_ways;
    logic [ADDR_W-1:0]  shifted;
    logic [SHAMT_W-1:0] tag_shamt;
    logic [SET_W:0]     set_mask;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
            ways_in_use_reg <= WAYS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[OFS_W-1:0];
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[IDXB_W-1:0];
                CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[USE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the settings and split the address.
    always_comb
    begin
        ib = (index_bits_reg > IDXB_W'(SET_W)) ? IDXB_W'(SET_W) : index_bits_reg;
        if (ways_in_use_reg == '0)
            use_ways = USE_W'(1);
        else if (ways_in_use_reg > USE_W'(WAYS))
            use_ways = USE_W'(WAYS);
        else
            use_ways = ways_in_use_reg;

        shifted   = address >> offset_bits_reg;
        set_mask  = ((SET_W+1)'(1) << ib) - (SET_W+1)'(1);
        tag_shamt = SHAMT_W'(offset_bits_reg) + SHAMT_W'(ib);

        lookup.set_idx  = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
        lookup.tag      = (tag_shamt < SHAMT_W'(32)) ? (address >> tag_shamt[4:0]) : '0;
        lookup.use_ways = use_ways;
    end

endmodule

[hw/rtl/sacl_queue.sv]
// ----------------------------------------------------------------------------
// sacl_queue
// Short queue of classified lookups between the front and back ends.
// ----------------------------------------------------------------------------
module sacl_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sacl_pkg::lookup_t push_data,
    input  logic              pop,
    output sacl_pkg::lookup_t head,
    output logic              full,
    output logic              empty
);
    import sacl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    lookup_t            slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (PTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PTR_W+1)'(1);
        end
    end

endmodule

[hw/rtl/sacl_back.sv]
// ----------------------------------------------------------------------------
// sacl_back
// Directory memory, hit/fill/replace decision, LRU update and result register.
// ----------------------------------------------------------------------------
module sacl_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  sacl_pkg::lookup_t            q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic [sacl_pkg::WAY_W-1:0]   way,
    output logic                         evicted
);
    import sacl_pkg::*;

    row_t            dir_mem [SETS];
    row_t            rd_row_reg;
    lookup_t         item_reg;
    logic [SETS-1:0] row_vld_reg;
    back_state_t     state_reg;
    back_state_t     state_next;

    logic            out_valid_reg;
    logic            hit_reg;
    logic [WAY_W-1:0] way_reg;
    logic            evicted_reg;

    logic            do_update;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] vcount;
    logic            found;
    logic            miss_fill;
    logic [WAY_W-1:0] w_sel;
    logic [RANK_W-1:0] best;
    logic [FILL_W-1:0] old_age;
    row_t            new_row;

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign way       = way_reg;
    assign evicted   = evicted_reg;

    // Sequencer: read a row, then decide and write it back.
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        do_update  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = BK_UPDATE;
                end
            end
            BK_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    do_update  = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Lookup decision and recency update on the row just read.
    always_comb
    begin
        fill    = row_vld_reg[item_reg.set_idx] ? rd_row_reg.fill : '0;
        vcount  = (fill < item_reg.use_ways) ? fill : item_reg.use_ways;
        found   = 1'b0;
        w_sel   = '0;
        best    = '0;
        new_row = rd_row_reg;

        // Lowest matching valid way wins.
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if ((FILL_W'(i) < vcount) && (rd_row_reg.tags[i] == item_reg.tag))
            begin
                found = 1'b1;
                w_sel = WAY_W'(i);
            end
        end

        miss_fill = !found && (fill < item_reg.use_ways);
        if (miss_fill)
            w_sel = fill[WAY_W-1:0];
        else if (!found)
        begin
            // Oldest way among those in use, lowest way on a tie.
            for (int i = 0; i < WAYS; i++)
            begin
                if ((FILL_W'(i) < item_reg.use_ways) && (rd_row_reg.ranks[i] > best))
                begin
                    best  = rd_row_reg.ranks[i];
                    w_sel = WAY_W'(i);
                end
            end
        end

        old_age = found ? FILL_W'(rd_row_reg.ranks[w_sel]) : FILL_W'(WAYS);

        // Age the filled ways that were younger than the touched one.
        for (int i = 0; i < WAYS; i++)
        begin
            if ((FILL_W'(i) < fill) && (WAY_W'(i) != w_sel)
                && (FILL_W'(rd_row_reg.ranks[i]) < old_age)
                && (rd_row_reg.ranks[i] < RANK_W'(WAYS - 1)))
                new_row.ranks[i] = rd_row_reg.ranks[i] + RANK_W'(1);
        end
        new_row.ranks[w_sel] = '0;
        if (!found)
            new_row.tags[w_sel] = item_reg.tag;
        new_row.fill = miss_fill ? fill + FILL_W'(1) : fill;
    end

    // Directory memory: row read on pop, write back on update.
    always_ff @(posedge clk)
    begin
        if (q_pop)
            rd_row_reg <= dir_mem[q_head.set_idx];
        if (do_update)
            dir_mem[item_reg.set_idx] <= new_row;
    end

    // Item being worked on and the result payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_head;
        if (do_update)
        begin
            hit_reg     <= found;
            way_reg     <= w_sel;
            evicted_reg <= !found && !miss_fill;
        end
    end

    // Control state: sequencer, row valid bits and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            row_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_update)
            begin
                row_vld_reg[item_reg.set_idx] <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

[hw/rtl/sacl_checker.sv]
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of the lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
module sacl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       hit,
    input logic [sacl_pkg::WAY_W-1:0] way,
    input logic                       evicted
);
    import sacl_pkg::*;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(way)
            && $stable(evicted))
        else $error("result changed while stalled");

    // A hit never evicts a line.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit reported with eviction");

    // A valid result carries a fully known payload.
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({hit, way, evicted}))
        else $error("result payload unknown");

    // The input side always gives a defined answer to an offered item.
    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_ready))
        else $error("in_ready unknown");

endmodule

bind set_assoc_cache_lru_lookup_unit sacl_checker u_sacl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .way       (way),
    .evicted   (evicted)
);
